@@ src/spr_pkg.sv @@
package spr_pkg;

   localparam int PULSE_W     = 12;
   localparam int MOVE_W      = 16;
   localparam int HOLD_W      = 22;
   localparam int MAX_RESULTS = 60;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [PULSE_W-1:0] HOME_PULSE      = 12'd500;
   localparam logic [PULSE_W-1:0] PULSE_MIN_RESET = 12'd0;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RESET = 12'd1000;
   localparam logic [HOLD_W-1:0]  HOLD_MAX        = 22'h3FFFFF;

   // register index, taken from address bit 2
   localparam logic REG_PULSE_MIN = 1'b0;
   localparam logic REG_PULSE_MAX = 1'b1;

   typedef struct packed {
      logic [PULSE_W-1:0] target_pulse;
      logic [MOVE_W-1:0]  move_time_ms;
   } req_item_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_out;
      logic [HOLD_W-1:0]  hold_ms;
      logic               last_step;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic div_step;
      logic emit_adv;
   } cmd_type;

   typedef struct packed {
      logic same_pos;
      logic div_done;
      logic last;
   } status_type;

endpackage

@@ src/spr_ctrl.sv @@
module spr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  spr_pkg::status_type status,
   output spr_pkg::cmd_type    cmd
);
   import spr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            // target already at position: nothing to emit
            if (status.same_pos) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_adv = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/spr_datapath.sv @@
module spr_datapath #(
   parameter int STEP_SIZE = 50
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spr_pkg::cmd_type             cmd,
   output spr_pkg::status_type          status,
   input  spr_pkg::req_item_type        req_item,
   input  logic [spr_pkg::PULSE_W-1:0]  pulse_min,
   input  logic [spr_pkg::PULSE_W-1:0]  pulse_max,
   output spr_pkg::rsp_item_type        rsp_item
);
   import spr_pkg::*;

   localparam int StepW    = $clog2(STEP_SIZE + 1);
   localparam int ProdW    = MOVE_W + StepW;
   localparam int CntW     = $clog2(ProdW);
   localparam int EmitCntW = $clog2(MAX_RESULTS);

   logic [PULSE_W-1:0]  pos_ff,  pos_in;
   logic [PULSE_W-1:0]  tgt_ff,  tgt_in;
   logic [MOVE_W-1:0]   move_ff, move_in;
   logic [PULSE_W-1:0]  dist_ff, dist_in;
   logic                up_ff,   up_in;
   logic [PULSE_W-1:0]  rem_ff,  rem_in;
   logic [ProdW-1:0]    quo_ff,  quo_in;
   logic [CntW-1:0]     div_cnt_ff, div_cnt_in;
   logic [PULSE_W-1:0]  val_ff,  val_in;
   logic [EmitCntW-1:0] emit_cnt_ff, emit_cnt_in;

   logic [PULSE_W-1:0]  clamped;
   logic [PULSE_W:0]    trial;
   logic                fits;
   logic [PULSE_W:0]    up_next;
   logic [PULSE_W:0]    dn_limit;
   logic                run_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= HOME_PULSE;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      move_ff     <= move_in;
      dist_ff     <= dist_in;
      up_ff       <= up_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      val_ff      <= val_in;
      emit_cnt_ff <= emit_cnt_in;
   end

   // minimum first, maximum wins when the bounds cross
   always_comb begin
      clamped = req_item.target_pulse;
      if (clamped < pulse_min) begin
         clamped = pulse_min;
      end
      if (clamped > pulse_max) begin
         clamped = pulse_max;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[ProdW-1]};
   assign fits  = trial >= {1'b0, dist_ff};

   assign up_next  = {1'b0, val_ff} + (PULSE_W+1)'(STEP_SIZE);
   assign dn_limit = {1'b0, tgt_ff} + (PULSE_W+1)'(STEP_SIZE);
   assign run_end  = up_ff ? (up_next >= {1'b0, tgt_ff}) : ({1'b0, val_ff} <= dn_limit);

   always_comb begin
      pos_in      = pos_ff;
      tgt_in      = tgt_ff;
      move_in     = move_ff;
      dist_in     = dist_ff;
      up_in       = up_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      div_cnt_in  = div_cnt_ff;
      val_in      = val_ff;
      emit_cnt_in = emit_cnt_ff;

      if (cmd.load) begin
         tgt_in  = clamped;
         move_in = req_item.move_time_ms;
      end

      if (cmd.setup) begin
         up_in       = tgt_ff > pos_ff;
         dist_in     = (tgt_ff > pos_ff) ? (tgt_ff - pos_ff) : (pos_ff - tgt_ff);
         quo_in      = ProdW'(move_ff) * ProdW'(STEP_SIZE);
         rem_in      = '0;
         div_cnt_in  = '0;
         val_in      = pos_ff;
         emit_cnt_in = '0;
      end

      if (cmd.div_step) begin
         if (fits) begin
            rem_in = PULSE_W'(trial - {1'b0, dist_ff});
         end else begin
            rem_in = trial[PULSE_W-1:0];
         end
         quo_in     = {quo_ff[ProdW-2:0], fits};
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (cmd.emit_adv) begin
         pos_in      = val_ff;
         val_in      = up_ff ? up_next[PULSE_W-1:0] : (val_ff - PULSE_W'(STEP_SIZE));
         emit_cnt_in = emit_cnt_ff + 1'b1;
      end
   end

   assign status.same_pos = tgt_ff == pos_ff;
   assign status.div_done = div_cnt_ff == CntW'(ProdW - 1);
   assign status.last     = run_end || (emit_cnt_ff == EmitCntW'(MAX_RESULTS - 1));

   assign rsp_item.pulse_out = val_ff;
   assign rsp_item.hold_ms   = (quo_ff > ProdW'(HOLD_MAX)) ? HOLD_MAX : quo_ff[HOLD_W-1:0];
   assign rsp_item.last_step = status.last;

endmodule

@@ src/servo_pulse_ramp.sv @@
// Slew-limited servo ramp. Each accepted move command is clamped to pulse_min and then
// pulse_max, and the block emits pulse values from the stored position toward the target
// in steps of STEP_SIZE, every one carrying the same hold time (move time * STEP_SIZE /
// distance, saturated to 22 bits), with last_step on the final one; at most 60 steps per
// command. A command whose clamped target equals the position emits nothing. One command
// is worked at a time: accept, a setup state, then the restoring divider, then one step
// per cycle while rsp_ready is high.
// The divider's one quotient bit per cycle and the step count set the time per command.
// Registers: pulse_min at 0x0 (reset 0), pulse_max at 0x4 (reset 1000), 12 bits each.
module servo_pulse_ramp #(
   parameter int STEP_SIZE = 50
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  spr_pkg::req_item_type           req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output spr_pkg::rsp_item_type           rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [spr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [spr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [spr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import spr_pkg::*;

   logic [PULSE_W-1:0] pulse_min_ff, pulse_min_in;
   logic [PULSE_W-1:0] pulse_max_ff, pulse_max_in;
   logic               csr_write;
   cmd_type            cmd;
   status_type         status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      pulse_min_in = pulse_min_ff;
      pulse_max_in = pulse_max_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_PULSE_MIN: pulse_min_in = pwdata[PULSE_W-1:0];
            REG_PULSE_MAX: pulse_max_in = pwdata[PULSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff <= PULSE_MIN_RESET;
         pulse_max_ff <= PULSE_MAX_RESET;
      end else begin
         pulse_min_ff <= pulse_min_in;
         pulse_max_ff <= pulse_max_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_PULSE_MIN: prdata = CSR_DATA_W'(pulse_min_ff);
         REG_PULSE_MAX: prdata = CSR_DATA_W'(pulse_max_ff);
         default:       prdata = '0;
      endcase
   end

   spr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spr_datapath #(
      .STEP_SIZE (STEP_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .pulse_min (pulse_min_ff),
      .pulse_max (pulse_max_ff),
      .rsp_item  (rsp_item)
   );

endmodule

@@ src/spr_checker.sv @@
module spr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input spr_pkg::req_item_type           req_item,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input spr_pkg::rsp_item_type           rsp_item,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [spr_pkg::CSR_ADDR_W-1:0]  paddr,
   input logic [spr_pkg::CSR_DATA_W-1:0]  pwdata,
   input logic [spr_pkg::CSR_DATA_W-1:0]  prdata,
   input logic                            pready
);
   import spr_pkg::*;

   // come out of reset ready for a command, with nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // one command at a time: no new item while steps are offered
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a step is pending");

   // an accepted command is worked before anything else is shown
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("accepted command not taken into setup");

   // a step without last_step is followed by another step
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_item.last_step |=> rsp_valid)
      else $error("ramp ended without last_step");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled step changed");

endmodule

bind servo_pulse_ramp spr_checker u_spr_checker (.*);
